// File: design/psa_vps_pkg.sv
// Shared constants and types of the PSA valve phase sequencer.
`default_nettype none

package psa_vps_pkg;

  // Reset values of the configuration registers.
  localparam logic [15:0] START_DELAY_RST     = 16'd1020;
  localparam logic [11:0] OFFSET_TIME_RST     = 12'd40;
  localparam logic [15:0] FRONT_HALF_TIME_RST = 16'd600;
  localparam logic [15:0] AFTER_HALF_TIME_RST = 16'd680;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_HALF_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AFTER_HALF_TIME = 2'd3;

  // Default width of the wrapping tick count.
  localparam int TIME_BITS_DEF = 32;

  // Derived thresholds never exceed 17 bits.
  localparam int THR_W = 17;

  // Ticks trimmed off the late start and the equalizing window.
  localparam int GUARD_TICKS = 10;

  // Valve level bit positions.
  localparam int NUM_VALVES = 5;
  localparam int BIT_FA = 0;
  localparam int BIT_FB = 1;
  localparam int BIT_WA = 2;
  localparam int BIT_WB = 3;
  localparam int BIT_EQ = 4;

  // Levels forced before the feed cycle may start: all open but EQ.
  localparam logic [NUM_VALVES-1:0] LEVELS_PRESTART = 5'b01111;

  typedef struct packed {
    logic [THR_W-1:0] wa_from;
    logic [THR_W-1:0] late_from;
    logic [THR_W-1:0] feed_from;
    logic [THR_W-1:0] wa_open_at;
    logic [THR_W-1:0] full;
    logic [THR_W-1:0] b_at;
    logic [THR_W-1:0] eq_end;
    logic [THR_W-1:0] front;
  } thr_t;

endpackage

`default_nettype wire

// File: design/psa_vps_cfg.sv
// Configuration registers and the thresholds derived from them.
`default_nettype none

module psa_vps_cfg
  import psa_vps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output thr_t                       thr_o
);

  logic [15:0] start_delay_q;
  logic [11:0] offset_time_q;
  logic [15:0] front_half_q;
  logic [15:0] after_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= START_DELAY_RST;
      offset_time_q <= OFFSET_TIME_RST;
      front_half_q  <= FRONT_HALF_TIME_RST;
      after_half_q  <= AFTER_HALF_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_DELAY:     start_delay_q <= cfg_wdata_i;
        CFG_OFFSET_TIME:     offset_time_q <= cfg_wdata_i[11:0];
        CFG_FRONT_HALF_TIME: front_half_q  <= cfg_wdata_i;
        CFG_AFTER_HALF_TIME: after_half_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [12:0] twice_o;
  logic [17:0] late_sum;

  assign twice_o  = {offset_time_q, 1'b0};
  assign late_sum = {2'b00, start_delay_q} + {5'd0, twice_o};

  // Thresholds that would go below zero are clamped to zero.
  always_comb begin
    thr_o.wa_from    = {1'b0, start_delay_q};
    thr_o.feed_from  = {1'b0, start_delay_q} + {5'd0, offset_time_q};
    thr_o.wa_open_at = {1'b0, front_half_q} + {4'd0, twice_o};
    thr_o.full       = {1'b0, front_half_q} + {1'b0, after_half_q};
    thr_o.front      = {1'b0, front_half_q};
    if (late_sum < 18'(GUARD_TICKS)) begin
      thr_o.late_from = '0;
    end else begin
      thr_o.late_from = THR_W'(late_sum - 18'(GUARD_TICKS));
    end
    if ({1'b0, after_half_q} < {4'd0, twice_o}) begin
      thr_o.b_at = '0;
    end else begin
      thr_o.b_at = {1'b0, after_half_q} - {4'd0, twice_o};
    end
    if (after_half_q < 16'(GUARD_TICKS)) begin
      thr_o.eq_end = '0;
    end else begin
      thr_o.eq_end = {1'b0, after_half_q - 16'(GUARD_TICKS)};
    end
  end

endmodule

`default_nettype wire

// File: design/psa_vps_step.sv
// Phase state of the four valve cycles and the per-tick step logic.
`default_nettype none

module psa_vps_step
  import psa_vps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [TIME_BITS-1:0]  now_i,
  input  wire thr_t                  thr_i,
  output logic [NUM_VALVES-1:0]      levels_d_o
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

  function automatic logic at_least(input logic [TIME_BITS-1:0] v,
                                    input logic [THR_W-1:0] t);
    return CMP_W'(v) >= CMP_W'(t);
  endfunction

  phase_e wa_phase_q, wa_phase_d;
  phase_e wb_phase_q, wb_phase_d;
  phase_e fd_phase_q, fd_phase_d;
  phase_e eq_phase_q, eq_phase_d;
  logic [TIME_BITS-1:0] wa_start_q, wa_start_d;
  logic [TIME_BITS-1:0] wb_start_q, wb_start_d;
  logic [TIME_BITS-1:0] fd_start_q, fd_start_d;
  logic [TIME_BITS-1:0] eq_start_q, eq_start_d;
  logic [NUM_VALVES-1:0] levels_q, levels_d;
  logic [TIME_BITS-1:0] e_wa, e_wb, e_fd, e_eq;

  assign e_wa = now_i - wa_start_q;
  assign e_wb = now_i - wb_start_q;
  assign e_fd = now_i - fd_start_q;
  assign e_eq = now_i - eq_start_q;

  // Steps run in the order WA, WB, feed, EQ; a later step overrides an earlier one.
  always_comb begin
    wa_phase_d = wa_phase_q;
    wb_phase_d = wb_phase_q;
    fd_phase_d = fd_phase_q;
    eq_phase_d = eq_phase_q;
    wa_start_d = wa_start_q;
    wb_start_d = wb_start_q;
    fd_start_d = fd_start_q;
    eq_start_d = eq_start_q;
    levels_d   = levels_q;

    if (at_least(now_i, thr_i.wa_from)) begin
      case (wa_phase_q)
        PH_IDLE: begin
          wa_phase_d       = PH_FIRST;
          levels_d[BIT_WA] = 1'b0;
          wa_start_d       = now_i;
        end
        PH_FIRST: begin
          if (at_least(e_wa, thr_i.wa_open_at) && !at_least(e_wa, thr_i.full)) begin
            levels_d[BIT_WA] = 1'b1;
            wa_phase_d       = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (at_least(e_wa, thr_i.full)) wa_phase_d = PH_IDLE;
        end
        default: ;
      endcase
    end

    if (at_least(now_i, thr_i.late_from)) begin
      case (wb_phase_q)
        PH_IDLE: begin
          wb_phase_d       = PH_FIRST;
          levels_d[BIT_WB] = 1'b1;
          wb_start_d       = now_i;
        end
        PH_FIRST: begin
          if (at_least(e_wb, thr_i.b_at) && !at_least(e_wb, thr_i.full)) begin
            levels_d[BIT_WB] = 1'b0;
            wb_phase_d       = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (at_least(e_wb, thr_i.full)) wb_phase_d = PH_IDLE;
        end
        default: ;
      endcase
    end

    if (at_least(now_i, thr_i.feed_from)) begin
      case (fd_phase_q)
        PH_IDLE: begin
          fd_phase_d       = PH_FIRST;
          levels_d[BIT_FA] = 1'b1;
          levels_d[BIT_FB] = 1'b0;
          fd_start_d       = now_i;
        end
        PH_FIRST: begin
          if (at_least(e_fd, thr_i.front)) begin
            levels_d[BIT_FA] = 1'b0;
            levels_d[BIT_FB] = 1'b1;
            fd_phase_d       = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (at_least(e_fd, thr_i.full)) fd_phase_d = PH_IDLE;
        end
        default: ;
      endcase
    end else begin
      levels_d = LEVELS_PRESTART;
    end

    if (at_least(now_i, thr_i.late_from)) begin
      case (eq_phase_q)
        PH_IDLE: begin
          eq_phase_d       = PH_FIRST;
          levels_d[BIT_EQ] = 1'b0;
          eq_start_d       = now_i;
        end
        PH_FIRST: begin
          if (at_least(e_eq, thr_i.b_at)) begin
            levels_d[BIT_EQ] = 1'b1;
            eq_phase_d       = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (at_least(e_eq, thr_i.eq_end)) eq_phase_d = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_phase_q <= PH_IDLE;
      wb_phase_q <= PH_IDLE;
      fd_phase_q <= PH_IDLE;
      eq_phase_q <= PH_IDLE;
      wa_start_q <= '0;
      wb_start_q <= '0;
      fd_start_q <= '0;
      eq_start_q <= '0;
      levels_q   <= '0;
    end else if (step_i) begin
      wa_phase_q <= wa_phase_d;
      wb_phase_q <= wb_phase_d;
      fd_phase_q <= fd_phase_d;
      eq_phase_q <= eq_phase_d;
      wa_start_q <= wa_start_d;
      wb_start_q <= wb_start_d;
      fd_start_q <= fd_start_d;
      eq_start_q <= eq_start_d;
      levels_q   <= levels_d;
    end
  end

  assign levels_d_o = levels_d;

endmodule

`default_nettype wire

// File: design/psa_valve_phase_sequencer_top.sv
// Top level of the PSA valve phase sequencer: handshake, input and result registers.
//
// Usage:
//   Each request on the input channel carries one tick count (current_time_i).
//   The block answers every request with exactly one result holding the five
//   valve levels after that tick, in request order.
//   A request is taken at a clock edge with in_valid_i high and in_stall_o low;
//   a result is taken at an edge with out_valid_o high and out_stall_i low.
//   A request taken at a clock edge lands in the input register, is stepped
//   through the phase logic, and its result is then registered in the result
//   register. One request per cycle is sustained while the receiver does not stall;
//   the phase state updates as an item moves into the result register, so the
//   next item sees it at once.
//   When the receiver stalls, the result register holds its value and the
//   input register keeps one more request; in_stall_o rises only when both are
//   full and the result is not being taken.
//   Reset clears both registers, all cycles go idle, the valves read closed,
//   and the configuration registers return to their defaults.
//   Configuration writes are taken whenever cfg_we_i is high, with no wait.
`default_nettype none

module psa_valve_phase_sequencer_top
  import psa_vps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [31:0]           current_time_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       feed_a_open_o,
  output logic                       feed_b_open_o,
  output logic                       waste_a_open_o,
  output logic                       waste_b_open_o,
  output logic                       equalize_open_o
);

  thr_t                  thr;
  logic                  in_valid_q, in_valid_d;
  logic [TIME_BITS-1:0]  in_time_q;
  logic                  out_valid_q, out_valid_d;
  logic [NUM_VALVES-1:0] out_levels_q;
  logic [NUM_VALVES-1:0] levels_d;
  logic                  advance;
  logic                  in_accept;

  psa_vps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  psa_vps_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .now_i      (in_time_q),
    .thr_i      (thr),
    .levels_d_o (levels_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_levels_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) out_levels_q <= levels_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_time_q <= current_time_i[TIME_BITS-1:0];
  end

  assign out_valid_o     = out_valid_q;
  assign feed_a_open_o   = out_levels_q[BIT_FA];
  assign feed_b_open_o   = out_levels_q[BIT_FB];
  assign waste_a_open_o  = out_levels_q[BIT_WA];
  assign waste_b_open_o  = out_levels_q[BIT_WB];
  assign equalize_open_o = out_levels_q[BIT_EQ];

endmodule

`default_nettype wire

// File: tb/tb_psa_valve_phase_sequencer_top.sv
// Self-checking testbench for the PSA valve phase sequencer with a built-in valve predictor.
`timescale 1ns / 100ps

module tb_psa_valve_phase_sequencer_top
  import psa_vps_pkg::*;
;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_ITEMS    = 168;
  localparam int unsigned DIRECTED_COUNT = 24;

  typedef enum logic [1:0] {
    CYC_IDLE   = 2'd0,
    CYC_FIRST  = 2'd1,
    CYC_SECOND = 2'd2
  } cyc_phase_e;

  typedef struct packed {
    cyc_phase_e  phase;
    logic [31:0] start;
  } valve_cycle_t;

  typedef struct packed {
    logic [31:0]           tick;
    logic                  typed;
    logic [NUM_VALVES-1:0] levels;
  } tick_row_t;

  // The first rows follow reset, before any cycle may start, so every valve but EQ reads open.
  localparam tick_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    '{32'd0,          1'b1, LEVELS_PRESTART},
    '{32'd1,          1'b1, LEVELS_PRESTART},
    '{32'd1019,       1'b1, LEVELS_PRESTART},
    '{32'd1020,       1'b0, '0},
    '{32'd1050,       1'b0, '0},
    '{32'd1060,       1'b0, '0},
    '{32'd1100,       1'b0, '0},
    '{32'd1660,       1'b0, '0},
    '{32'd1700,       1'b0, '0},
    '{32'd1740,       1'b0, '0},
    '{32'd2340,       1'b0, '0},
    '{32'd2341,       1'b0, '0},
    '{32'd2400,       1'b0, '0},
    '{32'd3000,       1'b0, '0},
    '{32'hFFFF_FFFF,  1'b0, '0},
    '{32'd0,          1'b0, '0},
    '{32'd1019,       1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'hFFFF_F000,  1'b0, '0},
    '{32'h0001_FFFF,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'h0000_FFFF,  1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_START_DELAY;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic [31:0]           current_time = '0;
  logic                  out_stall    = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  feed_a_open_o;
  logic                  feed_b_open_o;
  logic                  waste_a_open_o;
  logic                  waste_b_open_o;
  logic                  equalize_open_o;

  // Predictor copy of the configuration and of the valve cycles.
  logic [15:0] delay_cfg  = START_DELAY_RST;
  logic [11:0] offset_cfg = OFFSET_TIME_RST;
  logic [15:0] front_cfg  = FRONT_HALF_TIME_RST;
  logic [15:0] after_cfg  = AFTER_HALF_TIME_RST;

  valve_cycle_t          waste_a_cyc   = '{CYC_IDLE, 32'd0};
  valve_cycle_t          waste_b_cyc   = '{CYC_IDLE, 32'd0};
  valve_cycle_t          feed_cyc      = '{CYC_IDLE, 32'd0};
  valve_cycle_t          equalize_cyc  = '{CYC_IDLE, 32'd0};
  logic [NUM_VALVES-1:0] valve_levels  = '0;

  logic [NUM_VALVES-1:0] valve_expect_q [$];
  int unsigned           mismatch_count = 0;
  int unsigned           quiet_cycles   = 0;
  bit                    burst_mode     = 1'b0;
  bit                    long_hold_req  = 1'b0;

  psa_valve_phase_sequencer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .current_time_i  (current_time),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .feed_a_open_o   (feed_a_open_o),
    .feed_b_open_o   (feed_b_open_o),
    .waste_a_open_o  (waste_a_open_o),
    .waste_b_open_o  (waste_b_open_o),
    .equalize_open_o (equalize_open_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // Thresholds that work out below zero count as already met.
  function automatic logic [63:0] clamp_zero(input longint v);
    return (v < 0) ? 64'd0 : 64'(v);
  endfunction

  // Steps the four valve cycles for one tick and returns the valve levels after it.
  function automatic logic [NUM_VALVES-1:0] advance_valves(input logic [31:0] now);
    longint      d, o, f, a;
    logic [63:0] t, wa_from, late_from, feed_from, wa_open_at, full, b_at, eq_end, e;
    d          = longint'(delay_cfg);
    o          = longint'(offset_cfg);
    f          = longint'(front_cfg);
    a          = longint'(after_cfg);
    t          = {32'd0, now};
    wa_from    = clamp_zero(d);
    late_from  = clamp_zero(d + 2 * o - GUARD_TICKS);
    feed_from  = clamp_zero(d + o);
    wa_open_at = clamp_zero(f + 2 * o);
    full       = clamp_zero(f + a);
    b_at       = clamp_zero(a - 2 * o);
    eq_end     = clamp_zero(a - GUARD_TICKS);

    if (t >= wa_from) begin
      e = {32'd0, now - waste_a_cyc.start};
      if (waste_a_cyc.phase == CYC_IDLE) begin
        waste_a_cyc.phase    = CYC_FIRST;
        waste_a_cyc.start    = now;
        valve_levels[BIT_WA] = 1'b0;
      end else if (waste_a_cyc.phase == CYC_FIRST && e >= wa_open_at && e < full) begin
        waste_a_cyc.phase    = CYC_SECOND;
        valve_levels[BIT_WA] = 1'b1;
      end else if (waste_a_cyc.phase == CYC_SECOND && e >= full) begin
        waste_a_cyc.phase = CYC_IDLE;
      end
    end

    if (t >= late_from) begin
      e = {32'd0, now - waste_b_cyc.start};
      if (waste_b_cyc.phase == CYC_IDLE) begin
        waste_b_cyc.phase    = CYC_FIRST;
        waste_b_cyc.start    = now;
        valve_levels[BIT_WB] = 1'b1;
      end else if (waste_b_cyc.phase == CYC_FIRST && e >= b_at && e < full) begin
        waste_b_cyc.phase    = CYC_SECOND;
        valve_levels[BIT_WB] = 1'b0;
      end else if (waste_b_cyc.phase == CYC_SECOND && e >= full) begin
        waste_b_cyc.phase = CYC_IDLE;
      end
    end

    if (t >= feed_from) begin
      e = {32'd0, now - feed_cyc.start};
      if (feed_cyc.phase == CYC_IDLE) begin
        feed_cyc.phase       = CYC_FIRST;
        feed_cyc.start       = now;
        valve_levels[BIT_FA] = 1'b1;
        valve_levels[BIT_FB] = 1'b0;
      end else if (feed_cyc.phase == CYC_FIRST && e >= clamp_zero(f)) begin
        feed_cyc.phase       = CYC_SECOND;
        valve_levels[BIT_FA] = 1'b0;
        valve_levels[BIT_FB] = 1'b1;
      end else if (feed_cyc.phase == CYC_SECOND && e >= full) begin
        feed_cyc.phase = CYC_IDLE;
      end
    end else begin
      // Until the feed cycle may run, the waste and feed levels set above are overridden.
      valve_levels = LEVELS_PRESTART;
    end

    if (t >= late_from) begin
      e = {32'd0, now - equalize_cyc.start};
      if (equalize_cyc.phase == CYC_IDLE) begin
        equalize_cyc.phase   = CYC_FIRST;
        equalize_cyc.start   = now;
        valve_levels[BIT_EQ] = 1'b0;
      end else if (equalize_cyc.phase == CYC_FIRST && e >= b_at) begin
        equalize_cyc.phase   = CYC_SECOND;
        valve_levels[BIT_EQ] = 1'b1;
      end else if (equalize_cyc.phase == CYC_SECOND && e >= eq_end) begin
        equalize_cyc.phase = CYC_IDLE;
      end
    end
    return valve_levels;
  endfunction

  task automatic report_mismatch(input string what, input logic [NUM_VALVES-1:0] got,
                                 input logic [NUM_VALVES-1:0] want);
    $display("%0t: mismatch on %s: got %b, expected %b", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one tick request and records its expected valve levels, typed or predicted, once it is taken.
  task automatic offer_tick(input logic [31:0] tick, input logic typed,
                            input logic [NUM_VALVES-1:0] typed_levels);
    int unsigned           gap;
    logic [NUM_VALVES-1:0] predicted;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    current_time <= tick;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = advance_valves(tick);
    valve_expect_q.push_back(typed ? typed_levels : predicted);
  endtask

  task automatic wait_results_drained();
    while (valve_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [15:0] d, input logic [11:0] o,
                              input logic [15:0] f, input logic [15:0] a);
    logic [3:0] pad;
    pad = 4'($urandom_range(0, 15));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_DELAY;
    cfg_wdata <= d;
    @(posedge clk_i);
    // The upper bits of the offset write lie outside the register.
    cfg_index <= CFG_OFFSET_TIME;
    cfg_wdata <= {pad, o};
    @(posedge clk_i);
    cfg_index <= CFG_FRONT_HALF_TIME;
    cfg_wdata <= f;
    @(posedge clk_i);
    cfg_index <= CFG_AFTER_HALF_TIME;
    cfg_wdata <= a;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    delay_cfg  = d;
    offset_cfg = o;
    front_cfg  = f;
    after_cfg  = a;
  endtask

  // Mostly runs of rising ticks from a chosen base, with backward jumps and random noise mixed in.
  task automatic run_tick_phase(input int unsigned count, input bit with_hold,
                                input bit with_pause);
    logic [31:0] tick;
    int unsigned lead, step_max, run_left, pick, idx;
    lead     = delay_cfg + 2 * offset_cfg + 20;
    step_max = (front_cfg + after_cfg + 2 * offset_cfg) / 12 + 1;
    tick     = $urandom_range(0, lead);
    run_left = 0;
    for (idx = 0; idx < count; idx++) begin
      if (run_left == 0) begin
        run_left   = $urandom_range(8, 40);
        burst_mode = ($urandom_range(0, 3) == 0);
        pick       = $urandom_range(0, 3);
        if (pick == 0) tick = $urandom_range(0, lead);
        else if (pick == 1) tick = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
      end
      run_left--;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        offer_tick($urandom(), 1'b0, '0);
      end else begin
        if (pick == 1) tick = tick - $urandom_range(0, step_max);
        else tick = tick + $urandom_range(0, step_max);
        offer_tick(tick, 1'b0, '0);
      end
      if (with_hold && idx == count / 4) long_hold_req = 1'b1;
      if (with_pause && idx == count / 2) begin
        in_valid <= 1'b0;
        wait_results_drained();
      end
    end
  endtask

  initial begin : result_taker
    int unsigned hold;
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = burst_mode ? 0 : $urandom_range(0, 8);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!(rst_n && out_valid_o === 1'b1));
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [NUM_VALVES-1:0] got, want;
    string                 label;
    int                    bit_idx;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      got[BIT_FA] = feed_a_open_o;
      got[BIT_FB] = feed_b_open_o;
      got[BIT_WA] = waste_a_open_o;
      got[BIT_WB] = waste_b_open_o;
      got[BIT_EQ] = equalize_open_o;
      if (valve_expect_q.size() == 0) begin
        report_mismatch("result with no request pending", got, '0);
      end else begin
        want = valve_expect_q.pop_front();
        for (bit_idx = 0; bit_idx < NUM_VALVES; bit_idx++) begin
          if (got[bit_idx] !== want[bit_idx]) begin
            case (bit_idx)
              BIT_FA:  label = "feed_a_open";
              BIT_FB:  label = "feed_b_open";
              BIT_WA:  label = "waste_a_open";
              BIT_WB:  label = "waste_b_open";
              default: label = "equalize_open";
            endcase
            report_mismatch(label, NUM_VALVES'(got[bit_idx]), NUM_VALVES'(want[bit_idx]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
        $display("psa_valve_phase_sequencer_top verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_idx, row_idx;
    logic [15:0] d, f, a;
    logic [11:0] o;
    wait (rst_n === 1'b1);
    repeat (2) @(posedge clk_i);

    for (row_idx = 0; row_idx < DIRECTED_COUNT; row_idx++) begin
      offer_tick(DIRECTED_ROWS[row_idx].tick, DIRECTED_ROWS[row_idx].typed,
                 DIRECTED_ROWS[row_idx].levels);
    end
    in_valid <= 1'b0;
    wait_results_drained();

    for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      case (phase_idx)
        0: begin d = 16'd0;     o = 12'd0;    f = 16'd0;     a = 16'd0;     end
        1: begin d = 16'd0;     o = 12'd4095; f = 16'd1;     a = 16'd1;     end
        2: begin d = 16'hFFFF;  o = 12'd4095; f = 16'hFFFF;  a = 16'hFFFF;  end
        3: begin d = 16'd3;     o = 12'd2;    f = 16'd1;     a = 16'd5;     end
        4: begin d = 16'd0;     o = 12'd5;    f = 16'hFFFF;  a = 16'd1;     end
        5: begin d = 16'd1020;  o = 12'd40;   f = 16'd600;   a = 16'd680;   end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            d = 16'($urandom_range(0, 200));
            o = 12'($urandom_range(0, 60));
            f = 16'($urandom_range(1, 200));
            a = 16'($urandom_range(1, 200));
          end else begin
            d = 16'($urandom_range(0, 65535));
            o = 12'($urandom_range(0, 4095));
            f = 16'($urandom_range(1, 65535));
            a = 16'($urandom_range(1, 65535));
          end
        end
      endcase
      load_setting(d, o, f, a);
      run_tick_phase(PHASE_ITEMS, phase_idx == 5, phase_idx == 6);
      in_valid <= 1'b0;
      wait_results_drained();
    end

    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("psa_valve_phase_sequencer_top verification clean");
    end else begin
      $display("psa_valve_phase_sequencer_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/psa_vps_pkg.sv
design/psa_vps_cfg.sv
design/psa_vps_step.sv
design/psa_valve_phase_sequencer_top.sv
tb/tb_psa_valve_phase_sequencer_top.sv
